// ===== design/dual_button_toggle_pwm_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual button toggle PWM controller
// Property forms used by the controller top module, which checks itself.
// ----------------------------------------------------------------------------
`ifndef DUAL_BUTTON_TOGGLE_PWM_CONTROLLER_ASSERT_SVH
`define DUAL_BUTTON_TOGGLE_PWM_CONTROLLER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define DBTP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dbtp: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define DBTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dbtp: next-cycle check failed");

`endif

// ===== design/dbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dbtp_pkg
// Types and constants shared by the dual button toggle PWM controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dbtp_pkg;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_LAST    = 3'd0,
        CFG_ON0_AT         = 3'd1,
        CFG_OFF0_AT        = 3'd2,
        CFG_ON1_AT         = 3'd3,
        CFG_OFF1_AT        = 3'd4,
        CFG_PRESS_RELOAD   = 3'd5,
        CFG_RELEASE_RELOAD = 3'd6,
        CFG_TIMEOUT_LEN    = 3'd7
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_PERIOD_LAST    = 8'd29;
    localparam logic [7:0]  RST_ON0_AT         = 8'd2;
    localparam logic [7:0]  RST_OFF0_AT        = 8'd11;
    localparam logic [7:0]  RST_ON1_AT         = 8'd17;
    localparam logic [7:0]  RST_OFF1_AT        = 8'd26;
    localparam logic [7:0]  RST_PRESS_RELOAD   = 8'd4;
    localparam logic [7:0]  RST_RELEASE_RELOAD = 8'd10;
    localparam logic [15:0] RST_TIMEOUT_LEN    = 16'd60000;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [7:0]  period_last;
        logic [7:0]  on0_at;
        logic [7:0]  off0_at;
        logic [7:0]  on1_at;
        logic [7:0]  off1_at;
        logic [7:0]  press_reload;
        logic [7:0]  release_reload;
        logic [15:0] timeout_len;
    } cfg_t;

    // Status of one debounce channel for the current tick.
    typedef struct packed {
        logic level_after;  // debounced level after this tick
        logic flip;         // debounced level changes this tick
        logic press;        // the change is to the pressed level
    } db_status_t;

    // PWM compare phase: which compare point is armed.
    typedef enum logic [1:0] {
        PH_ON0  = 2'd0,
        PH_OFF0 = 2'd1,
        PH_ON1  = 2'd2,
        PH_OFF1 = 2'd3
    } phase_t;

endpackage

`default_nettype wire

// ===== design/dbtp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dbtp_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dbtp_cfg_regs
    import dbtp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; cfg_ready is tied high.
    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Decode the register index of a write request.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_PERIOD_LAST:    cfg_next.period_last    = cfg_data[7:0];
                CFG_ON0_AT:         cfg_next.on0_at         = cfg_data[7:0];
                CFG_OFF0_AT:        cfg_next.off0_at        = cfg_data[7:0];
                CFG_ON1_AT:         cfg_next.on1_at         = cfg_data[7:0];
                CFG_OFF1_AT:        cfg_next.off1_at        = cfg_data[7:0];
                CFG_PRESS_RELOAD:   cfg_next.press_reload   = cfg_data[7:0];
                CFG_RELEASE_RELOAD: cfg_next.release_reload = cfg_data[7:0];
                CFG_TIMEOUT_LEN:    cfg_next.timeout_len    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_last    <= RST_PERIOD_LAST;
            cfg_reg.on0_at         <= RST_ON0_AT;
            cfg_reg.off0_at        <= RST_OFF0_AT;
            cfg_reg.on1_at         <= RST_ON1_AT;
            cfg_reg.off1_at        <= RST_OFF1_AT;
            cfg_reg.press_reload   <= RST_PRESS_RELOAD;
            cfg_reg.release_reload <= RST_RELEASE_RELOAD;
            cfg_reg.timeout_len    <= RST_TIMEOUT_LEN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dbtp_debounce.sv =====
// ----------------------------------------------------------------------------
// dbtp_debounce
// Counter based debouncer for one button, evaluated once per period end.
// ----------------------------------------------------------------------------
`default_nettype none

module dbtp_debounce
    import dbtp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,         // an input item is accepted
    input  wire logic       period_end,   // the current tick ends a period
    input  wire logic       raw,
    input  wire logic [7:0] press_reload,
    input  wire logic [7:0] release_reload,
    output db_status_t      status
);

    logic       level_reg;
    logic       level_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       flip;

    // Reload while stable, count down while the raw level disagrees,
    // and flip the debounced level when the count runs out.
    always_comb begin
        flip       = 1'b0;
        level_next = level_reg;
        if (raw == level_reg) begin
            count_next = level_reg ? press_reload : release_reload;
        end else if (count_reg == 8'd0) begin
            flip       = 1'b1;
            level_next = ~level_reg;
            count_next = level_reg ? release_reload : press_reload;
        end else begin
            count_next = count_reg - 8'd1;
        end
    end

    // Report the result only on a period end.
    always_comb begin
        status.flip        = period_end & flip;
        status.press       = period_end & flip & level_reg;
        status.level_after = period_end ? level_next : level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            count_reg <= 8'd0;
        end else if (step && period_end) begin
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dual_button_toggle_pwm_controller.sv =====
// ----------------------------------------------------------------------------
// dual_button_toggle_pwm_controller
// Two debounced toggle buttons enabling a phased, non-overlapping two-channel
// PWM, with an inactivity timeout and a sleep request.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_button0_level, s_button1_level
//   m_        out        m_valid / m_ready    m_drive0, m_drive1, m_sleep_request
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each timer tick is processed combinationally; one result per tick appears in
// the output register the cycle after the tick is accepted.
// A new tick is accepted every cycle while the output register is empty or
// being drained, so throughput is one tick per cycle without backpressure.
// A stall on m_ready holds the result and stops input acceptance.
// Reset is synchronous; no clearing pass.
// Configuration writes are accepted every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_button_toggle_pwm_controller
    import dbtp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_button0_level,
    input  wire logic                 s_button1_level,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_drive0,
    output logic                      m_drive1,
    output logic                      m_sleep_request,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    cfg_t       cfg;
    db_status_t db0;
    db_status_t db1;

    logic        accept;
    logic        period_end;
    logic [7:0]  tick_reg;
    logic [7:0]  tick_next;
    logic [15:0] idle_reg;
    logic [15:0] idle_next;
    logic [1:0]  enable_reg;
    logic [1:0]  enable_next;
    logic [1:0]  drive_reg;
    logic [1:0]  drive_mid;
    logic [1:0]  drive_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  point;
    logic        match;
    logic        sleep_next;

    logic        m_valid_reg;
    logic        m_drive0_reg;
    logic        m_drive1_reg;
    logic        m_sleep_reg;

    // Configuration registers.
    dbtp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: take a request when the result register is free or draining.
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign period_end = (tick_reg == cfg.period_last);

    // One debouncer per button.
    dbtp_debounce u_db0 (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (accept),
        .period_end     (period_end),
        .raw            (s_button0_level),
        .press_reload   (cfg.press_reload),
        .release_reload (cfg.release_reload),
        .status         (db0)
    );

    dbtp_debounce u_db1 (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (accept),
        .period_end     (period_end),
        .raw            (s_button1_level),
        .press_reload   (cfg.press_reload),
        .release_reload (cfg.release_reload),
        .status         (db1)
    );

    // Tick counter wraps after the last tick of the period.
    assign tick_next = period_end ? 8'd0 : tick_reg + 8'd1;

    // Idle timer: any debounced change reloads it, every period end counts
    // it down, and reaching zero switches both channels off.
    always_comb begin
        idle_next   = ((db0.flip || db1.flip) ? cfg.timeout_len : idle_reg) - 16'd1;
        enable_next = enable_reg ^ {db1.press, db0.press};
        if (period_end && (idle_next == 16'd0)) begin
            enable_next = 2'b00;
        end
    end

    // Compare point armed by the current phase.
    always_comb begin
        case (phase_reg)
            PH_ON0:  point = cfg.on0_at;
            PH_OFF0: point = cfg.off0_at;
            PH_ON1:  point = cfg.on1_at;
            PH_OFF1: point = cfg.off1_at;
            default: point = cfg.off1_at;
        endcase
        match = (enable_next != 2'b00) && (tick_reg == point);
    end

    // Next phase: advance one step on a compare match.
    always_comb begin
        phase_next = match ? phase_t'(phase_reg + 2'd1) : phase_reg;
    end

    // Output levels: the matched point switches its output, and a disabled
    // channel is always forced low.
    always_comb begin
        drive_mid = drive_reg;
        if (match) begin
            case (phase_reg)
                PH_ON0:  drive_mid[0] = drive_reg[0] | enable_next[0];
                PH_OFF0: drive_mid[0] = 1'b0;
                PH_ON1:  drive_mid[1] = drive_reg[1] | enable_next[1];
                PH_OFF1: drive_mid[1] = 1'b0;
                default: drive_mid    = drive_reg;
            endcase
        end
        drive_next = drive_mid & enable_next;
        sleep_next = (enable_next == 2'b00) && db0.level_after && db1.level_after &&
                     s_button0_level && s_button1_level;
    end

    // Tick state advances on every accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg   <= 8'd0;
            idle_reg   <= 16'd0;
            enable_reg <= 2'b00;
            drive_reg  <= 2'b00;
            phase_reg  <= PH_ON0;
        end else if (accept) begin
            tick_reg   <= tick_next;
            enable_reg <= enable_next;
            drive_reg  <= drive_next;
            phase_reg  <= phase_next;
            if (period_end) begin
                idle_reg <= idle_next;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_drive0_reg <= drive_next[0];
            m_drive1_reg <= drive_next[1];
            m_sleep_reg  <= sleep_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive0        = m_drive0_reg;
    assign m_drive1        = m_drive1_reg;
    assign m_sleep_request = m_sleep_reg;

`include "dual_button_toggle_pwm_controller_assert.svh"

    // Output zero can only be on between its on and off points.
    `DBTP_ASSERT_SAME(a_drive0_phase, aclk, aresetn, drive_reg[0], phase_reg == PH_OFF0)
    // Output one can only be on between its on and off points.
    `DBTP_ASSERT_SAME(a_drive1_phase, aclk, aresetn, drive_reg[1], phase_reg == PH_OFF1)
    // A driven output always belongs to an enabled channel.
    `DBTP_ASSERT_SAME(a_drive_enabled, aclk, aresetn, drive_reg != 2'b00,
                      (drive_reg & ~enable_reg) == 2'b00)
    // An accepted tick always produces a result in the next cycle.
    `DBTP_ASSERT_NEXT(a_accept_result, aclk, aresetn, accept, m_valid_reg)

endmodule

`default_nettype wire

// ===== tb/dbtp_dimmer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dbtp_dimmer_checker
// Watches the tick, result and register channels of the dual button toggle
// PWM controller. It keeps its own copy of the register file and of the
// debounce, enable, timeout and PWM phase state, works out the output levels
// that each accepted tick must produce, and compares them in order with the
// results that the block delivers. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module dbtp_dimmer_checker
    import dbtp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_button0_level,
    input  logic                 s_button1_level,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_drive0,
    input  logic                 m_drive1,
    input  logic                 m_sleep_request,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int unsigned          fail_count,
    output int unsigned          pending
);

    typedef struct packed {
        logic drive0;
        logic drive1;
        logic sleep_request;
    } lamp_state_t;

    // Mirror of the register file and of the controller state.
    cfg_t        regs;
    logic [7:0]  tick;
    phase_t      phase;
    logic [1:0]  db_level;
    logic [7:0]  db_count [2];
    logic [1:0]  enable;
    logic [1:0]  drive;
    logic [15:0] idle_timer;

    // Output levels still owed by the block, oldest first.
    lamp_state_t expected_lamps [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // A released button waits on the press reload, a pressed one on the release reload.
    function automatic logic [7:0] debounce_reload(input logic level);
        return level ? regs.press_reload : regs.release_reload;
    endfunction

    // One period-end debounce step for one button.
    task automatic debounce_button(input int ch, input logic raw);
        if (raw == db_level[ch]) begin
            db_count[ch] = debounce_reload(db_level[ch]);
        end else if (db_count[ch] == 8'd0) begin
            db_level[ch] = ~db_level[ch];
            db_count[ch] = debounce_reload(db_level[ch]);
            // Only a press toggles the channel; any accepted edge restarts the timeout.
            if (!db_level[ch]) enable[ch] = ~enable[ch];
            idle_timer = regs.timeout_len;
        end else begin
            db_count[ch] = db_count[ch] - 8'd1;
        end
    endtask

    // Advances the mirrored state by one tick and returns the output levels.
    task automatic advance_dimmer_tick(input logic raw0, input logic raw1,
                                       output lamp_state_t lamps);
        logic [7:0] point;
        logic       at_end;

        at_end = (tick == regs.period_last);

        // Period end: debounce both buttons, then run the inactivity timer.
        if (at_end) begin
            debounce_button(0, raw0);
            debounce_button(1, raw1);
            idle_timer = idle_timer - 16'd1;
            if (idle_timer == 16'd0) enable = 2'b00;
        end

        // Only the armed compare point is checked, and only while a channel is on.
        if (enable != 2'b00) begin
            case (phase)
                PH_ON0:  point = regs.on0_at;
                PH_OFF0: point = regs.off0_at;
                PH_ON1:  point = regs.on1_at;
                default: point = regs.off1_at;
            endcase
            if (tick == point) begin
                case (phase)
                    PH_ON0:  if (enable[0]) drive[0] = 1'b1;
                    PH_OFF0: drive[0] = 1'b0;
                    PH_ON1:  if (enable[1]) drive[1] = 1'b1;
                    default: drive[1] = 1'b0;
                endcase
                phase = phase_t'(phase + 2'd1);
            end
        end

        // A disabled channel never drives.
        drive = drive & enable;
        tick  = at_end ? 8'd0 : tick + 8'd1;

        lamps.drive0        = drive[0];
        lamps.drive1        = drive[1];
        lamps.sleep_request = (enable == 2'b00) && (db_level == 2'b11) && raw0 && raw1;
    endtask

    always @(posedge aclk) begin : watch
        lamp_state_t want;
        lamp_state_t lamps;

        if (!aresetn) begin
            regs = {RST_PERIOD_LAST, RST_ON0_AT, RST_OFF0_AT, RST_ON1_AT, RST_OFF1_AT,
                    RST_PRESS_RELOAD, RST_RELEASE_RELOAD, RST_TIMEOUT_LEN};
            tick        = 8'd0;
            phase       = PH_ON0;
            db_level    = 2'b00;
            db_count[0] = 8'd0;
            db_count[1] = 8'd0;
            enable      = 2'b00;
            drive       = 2'b00;
            idle_timer  = 16'd0;
            expected_lamps.delete();
        end else begin
            // Compare a delivered result with the oldest expectation.
            if (m_valid && m_ready) begin
                if (expected_lamps.size() == 0) begin
                    $error("result with no request outstanding: drive0 %0b drive1 %0b sleep %0b",
                           m_drive0, m_drive1, m_sleep_request);
                    fail_count++;
                end else begin
                    want = expected_lamps.pop_front();
                    if (m_drive0 !== want.drive0) begin
                        $error("drive0: expected %0b, actual %0b", want.drive0, m_drive0);
                        fail_count++;
                    end
                    if (m_drive1 !== want.drive1) begin
                        $error("drive1: expected %0b, actual %0b", want.drive1, m_drive1);
                        fail_count++;
                    end
                    if (m_sleep_request !== want.sleep_request) begin
                        $error("sleep_request: expected %0b, actual %0b",
                               want.sleep_request, m_sleep_request);
                        fail_count++;
                    end
                end
            end

            // Register writes; narrow registers keep the low byte only.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PERIOD_LAST:    regs.period_last    = cfg_data[7:0];
                    CFG_ON0_AT:         regs.on0_at         = cfg_data[7:0];
                    CFG_OFF0_AT:        regs.off0_at        = cfg_data[7:0];
                    CFG_ON1_AT:         regs.on1_at         = cfg_data[7:0];
                    CFG_OFF1_AT:        regs.off1_at        = cfg_data[7:0];
                    CFG_PRESS_RELOAD:   regs.press_reload   = cfg_data[7:0];
                    CFG_RELEASE_RELOAD: regs.release_reload = cfg_data[7:0];
                    CFG_TIMEOUT_LEN:    regs.timeout_len    = cfg_data;
                    default: ;
                endcase
            end

            // Every accepted tick owes exactly one result.
            if (s_valid && s_ready) begin
                advance_dimmer_tick(s_button0_level, s_button1_level, lamps);
                expected_lamps.push_back(lamps);
            end
        end
        pending = expected_lamps.size();
    end

endmodule

// ===== tb/tb_dual_button_toggle_pwm_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_button_toggle_pwm_controller
// Drives timer ticks with two button levels into the controller under
// several register settings: a warm-up on the reset values, a short directed
// part, then button gestures with bounce and noise under random and extreme
// settings. The tick channel idles at random. A checker module predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_button_toggle_pwm_controller;
    import dbtp_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ROUNDS = 8;
    localparam int HOLD_CAP      = 600;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_button0_level = 1'b1;
    logic                 s_button1_level = 1'b1;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_drive0;
    logic                 m_drive1;
    logic                 m_sleep_request;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [15:0]          cfg_data        = '0;

    int unsigned fail_count;
    int unsigned pending;
    int          stall_cycles = 0;
    logic        steady       = 1'b0;
    logic [15:0] setting [8];

    always #1 aclk = ~aclk;

    dual_button_toggle_pwm_controller u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button0_level (s_button0_level),
        .s_button1_level (s_button1_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive0        (m_drive0),
        .m_drive1        (m_drive1),
        .m_sleep_request (m_sleep_request),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    dbtp_dimmer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button0_level (s_button0_level),
        .s_button1_level (s_button1_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive0        (m_drive0),
        .m_drive1        (m_drive1),
        .m_sleep_request (m_sleep_request),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // Result side stalls at random about 29 percent of the time, except in steady stretches.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 29);
    end

    // Watchdog: too many cycles in a row with no request moving on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("dual_button_toggle_pwm_controller test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one tick and waits for it to be taken, then maybe idles a while.
    task automatic send_tick(input logic b0, input logic b1);
        s_valid         <= 1'b1;
        s_button0_level <= b0;
        s_button1_level <= b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 29);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Writes all eight registers back to back; narrow ones get junk in the upper byte.
    task automatic apply_setting();
        logic [15:0] data;
        for (int i = 0; i < 8; i++) begin
            data = setting[i];
            if (cfg_index_t'(i) != CFG_TIMEOUT_LEN) data[15:8] = 8'($urandom_range(255));
            write_reg(cfg_index_t'(i), data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stops offering ticks and waits until every result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        logic [1:0] quick_taps [10];
        logic [1:0] timeout_taps [12];
        logic [1:0] target;
        logic [1:0] raw;
        int         hold [2];
        int         span;
        int         reload_max;
        int         periods;
        int         n_items;

        quick_taps   = '{2'b11, 2'b10, 2'b11, 2'b01, 2'b11,
                         2'b00, 2'b11, 2'b00, 2'b11, 2'b10};
        timeout_taps = '{2'b11, 2'b11, 2'b10, 2'b10, 2'b11, 2'b11,
                         2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One full period on the reset values: the first release lands at its end.
        for (int n = 0; n <= RST_PERIOD_LAST; n++) send_tick(1'b1, 1'b1);
        drain();

        // Every tick is a period end, all compare points coincide, zero reloads,
        // and a zero timeout that wraps instead of switching off.
        setting[CFG_PERIOD_LAST]    = 16'd0;
        setting[CFG_ON0_AT]         = 16'd0;
        setting[CFG_OFF0_AT]        = 16'd0;
        setting[CFG_ON1_AT]         = 16'd0;
        setting[CFG_OFF1_AT]        = 16'd0;
        setting[CFG_PRESS_RELOAD]   = 16'd0;
        setting[CFG_RELEASE_RELOAD] = 16'd0;
        setting[CFG_TIMEOUT_LEN]    = 16'd0;
        apply_setting();
        foreach (quick_taps[i]) send_tick(quick_taps[i][0], quick_taps[i][1]);
        drain();

        // Two-tick periods, channel one's compare beyond the period end,
        // and a short timeout that switches both channels off.
        setting[CFG_PERIOD_LAST]    = 16'd1;
        setting[CFG_ON0_AT]         = 16'd0;
        setting[CFG_OFF0_AT]        = 16'd1;
        setting[CFG_ON1_AT]         = 16'd5;
        setting[CFG_OFF1_AT]        = 16'd255;
        setting[CFG_PRESS_RELOAD]   = 16'd0;
        setting[CFG_RELEASE_RELOAD] = 16'd1;
        setting[CFG_TIMEOUT_LEN]    = 16'd2;
        apply_setting();
        foreach (timeout_taps[i]) send_tick(timeout_taps[i][0], timeout_taps[i][1]);
        drain();

        // Random gestures: held levels with bounce, under a new setting each round.
        target = 2'b11;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            if (round == 0) begin
                // Smallest values: immediate timeout after every accepted edge.
                setting[CFG_PERIOD_LAST]    = 16'd1;
                setting[CFG_ON0_AT]         = 16'd0;
                setting[CFG_OFF0_AT]        = 16'd0;
                setting[CFG_ON1_AT]         = 16'd1;
                setting[CFG_OFF1_AT]        = 16'd1;
                setting[CFG_PRESS_RELOAD]   = 16'd0;
                setting[CFG_RELEASE_RELOAD] = 16'd0;
                setting[CFG_TIMEOUT_LEN]    = 16'd1;
            end else if (round == RANDOM_ROUNDS - 1) begin
                // Largest values; kept last since its long period is slow.
                setting[CFG_PERIOD_LAST]    = 16'd255;
                setting[CFG_ON0_AT]         = 16'd0;
                setting[CFG_OFF0_AT]        = 16'd127;
                setting[CFG_ON1_AT]         = 16'd128;
                setting[CFG_OFF1_AT]        = 16'd255;
                setting[CFG_PRESS_RELOAD]   = 16'd255;
                setting[CFG_RELEASE_RELOAD] = 16'd255;
                setting[CFG_TIMEOUT_LEN]    = 16'd65535;
            end else begin
                // Short periods; compare points sometimes past the period end.
                span = $urandom_range(7);
                setting[CFG_PERIOD_LAST]    = 16'(span);
                setting[CFG_ON0_AT]         = 16'($urandom_range(span + 2));
                setting[CFG_OFF0_AT]        = 16'($urandom_range(span + 2));
                setting[CFG_ON1_AT]         = 16'($urandom_range(span + 2));
                setting[CFG_OFF1_AT]        = 16'($urandom_range(span + 2));
                setting[CFG_PRESS_RELOAD]   = 16'($urandom_range(3));
                setting[CFG_RELEASE_RELOAD] = 16'($urandom_range(3));
                if ($urandom_range(3) != 0)
                    setting[CFG_TIMEOUT_LEN] = 16'($urandom_range(1, 40));
                else
                    setting[CFG_TIMEOUT_LEN] = 16'($urandom_range(65535));
            end
            apply_setting();

            span       = setting[CFG_PERIOD_LAST][7:0];
            reload_max = setting[CFG_PRESS_RELOAD][7:0];
            if (setting[CFG_RELEASE_RELOAD][7:0] > reload_max)
                reload_max = setting[CFG_RELEASE_RELOAD][7:0];
            steady = (round == 3);
            // Whole periods per setting but the last, so the tick counter is back at
            // zero for the next one.
            n_items = (round == RANDOM_ROUNDS - 1) ? 300 : (190 / (span + 1)) * (span + 1);
            hold[0] = 0;
            hold[1] = 0;

            for (int n = 0; n < n_items; n++) begin
                for (int ch = 0; ch < 2; ch++) begin
                    if (hold[ch] == 0) begin
                        if ($urandom_range(99) < 60) target[ch] = ~target[ch];
                        if ($urandom_range(99) < 15) begin
                            // Short holds, up to reload_max + 1 periods, that may be too short to pass the debounce.
                            periods = $urandom_range(1, reload_max + 1);
                        end else begin
                            periods = reload_max + 1 + $urandom_range(3);
                            // Long rests let the inactivity timeout expire.
                            if (target[ch] && $urandom_range(3) == 0)
                                periods += $urandom_range(10, 60);
                        end
                        hold[ch] = periods * (span + 1);
                        if (hold[ch] > HOLD_CAP) hold[ch] = HOLD_CAP;
                    end
                    hold[ch]--;
                    // Occasional bounce against the held level.
                    raw[ch] = target[ch] ^ ($urandom_range(99) < 6);
                end
                send_tick(raw[0], raw[1]);
            end
            drain();
            steady = 1'b0;
        end

        repeat (4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("dual_button_toggle_pwm_controller test passed");
        end else begin
            $display("dual_button_toggle_pwm_controller test failed");
        end
        $finish;
    end

endmodule
